>>> rtl/drc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_pkg
// Shared types, register indexes and constants of the grid raycaster.
// ============================================================================
package drc_pkg;

    // Parameter defaults
    localparam int MAP_SIDE_DEF   = 64;
    localparam int TEX_SIZE_DEF   = 512;
    localparam int MAX_SCREEN_DEF = 2048;

    // Fixed widths
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SCR_W       = 13;
    localparam int DIV_W       = 32;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd7;

    // Register reset values
    localparam logic [13:0] RST_PLAYER_X      = 14'd2048;
    localparam logic [13:0] RST_PLAYER_Y      = 14'd2048;
    localparam logic [15:0] RST_DIR_X         = 16'd0;
    localparam logic [15:0] RST_DIR_Y         = 16'd16384;
    localparam logic [15:0] RST_PLANE_X       = 16'd10813;
    localparam logic [15:0] RST_PLANE_Y       = 16'd0;
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd480;

    // Wall face codes
    localparam logic [1:0] FACE_N = 2'd0;
    localparam logic [1:0] FACE_S = 2'd1;
    localparam logic [1:0] FACE_W = 2'd2;
    localparam logic [1:0] FACE_E = 2'd3;

    // Status codes
    localparam logic ST_HIT  = 1'b0;
    localparam logic ST_LEFT = 1'b1;

    // Input item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    typedef enum logic {
        K_WRITE,
        K_CAST
    } t_drc_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CAM,
        S_RAY,
        S_DXI,
        S_DX,
        S_DY,
        S_SIDE,
        S_STEP,
        S_CHECK,
        S_DIST,
        S_LHI,
        S_LH,
        S_TS,
        S_ST
    } t_drc_state;

    typedef struct packed {
        logic        mode;
        logic [10:0] column;
        logic [11:0] cell_index;
        logic        cell_is_wall;
    } t_drc_in;

    typedef struct packed {
        logic [10:0] column_out;
        logic        status;
        logic [1:0]  wall_face;
        logic [15:0] wall_distance;
        logic [15:0] line_height;
        logic [10:0] draw_start;
        logic [10:0] draw_end;
        logic [8:0]  tex_x;
        logic [24:0] tex_step;
        logic [24:0] tex_start;
    } t_drc_out;

    typedef struct packed {
        t_drc_kind   kind;
        logic [10:0] column;
        logic [11:0] cell_addr;
        logic        wall;
    } t_drc_op;

    typedef struct packed {
        logic [13:0] player_x;
        logic [13:0] player_y;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] plane_x;
        logic [15:0] plane_y;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
    } t_drc_cfg;

endpackage

>>> rtl/dda_raycast_wall_column.sv
`timescale 1ns / 1ps
// ============================================================================
// dda_raycast_wall_column
// Grid-map DDA raycaster: map cell writes and one textured wall column per
// cast item.
// ============================================================================
//  channel  direction  signals                              accepted when
//  in       input      i_in_valid, o_in_stall, i_in_data    valid & !stall
//  out      output     o_out_valid, i_out_stall, o_out_data valid & !stall
//  cfg      input      i_cfg_we, i_cfg_index, i_cfg_data    we
//
//  A map write is done in the back end's idle state. A cast makes six
//  passes through the shared one-bit-per-cycle divider, and each DDA step
//  goes through S_STEP and S_CHECK, since the map read is registered.
//  After reset the map is swept empty with input stalled. A two-entry
//  queue lets items in while a cast runs; a finished result waits in the
//  output register while the next item proceeds.
// ============================================================================
module dda_raycast_wall_column #(
    parameter int MAP_SIDE   = drc_pkg::MAP_SIDE_DEF,
    parameter int TEX_SIZE   = drc_pkg::TEX_SIZE_DEF,
    parameter int MAX_SCREEN = drc_pkg::MAX_SCREEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  drc_pkg::t_drc_in                   i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output drc_pkg::t_drc_out                  o_out_data,
    input  logic                               i_cfg_we,
    input  logic [drc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [drc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    drc_pkg::t_drc_cfg r_cfg;
    drc_pkg::t_drc_op  push_op;
    drc_pkg::t_drc_op  q_op;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    logic              clearing;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.player_x      <= drc_pkg::RST_PLAYER_X;
            r_cfg.player_y      <= drc_pkg::RST_PLAYER_Y;
            r_cfg.dir_x         <= drc_pkg::RST_DIR_X;
            r_cfg.dir_y         <= drc_pkg::RST_DIR_Y;
            r_cfg.plane_x       <= drc_pkg::RST_PLANE_X;
            r_cfg.plane_y       <= drc_pkg::RST_PLANE_Y;
            r_cfg.screen_width  <= drc_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height <= drc_pkg::RST_SCREEN_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                drc_pkg::CFG_PLAYER_X:      r_cfg.player_x      <= i_cfg_data[13:0];
                drc_pkg::CFG_PLAYER_Y:      r_cfg.player_y      <= i_cfg_data[13:0];
                drc_pkg::CFG_DIR_X:         r_cfg.dir_x         <= i_cfg_data;
                drc_pkg::CFG_DIR_Y:         r_cfg.dir_y         <= i_cfg_data;
                drc_pkg::CFG_PLANE_X:       r_cfg.plane_x       <= i_cfg_data;
                drc_pkg::CFG_PLANE_Y:       r_cfg.plane_y       <= i_cfg_data;
                drc_pkg::CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[11:0];
                drc_pkg::CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    drc_front #(
        .MAP_SIDE (MAP_SIDE)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_op       (push_op)
    );

    drc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_op    (q_op)
    );

    drc_back #(
        .MAP_SIDE   (MAP_SIDE),
        .TEX_SIZE   (TEX_SIZE),
        .MAX_SCREEN (MAX_SCREEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_op      (q_op),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/drc_div.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by all
// divisions of a cast.
// ============================================================================
module drc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [drc_pkg::DIV_W-1:0]  i_num,
    input  logic [drc_pkg::DIV_W-1:0]  i_den,
    output logic                       o_done,
    output logic [drc_pkg::DIV_W-1:0]  o_quot
);
    localparam int W  = drc_pkg::DIV_W;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [W+1:0]  diff;
    logic [W-1:0]  n_rem;
    logic [W-1:0]  n_quo;

    // Trial subtract of the shifted remainder
    always_comb begin
        diff = {1'b0, r_rem, r_quo[W-1]} - {2'b00, r_den};
        if (diff[W+1]) begin
            n_rem = {r_rem[W-2:0], r_quo[W-1]};
        end else begin
            n_rem = diff[W-1:0];
        end
        n_quo = {r_quo[W-2:0], ~diff[W+1]};
    end

    // Control: count the iterations, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> rtl/drc_front.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_front
// Takes input items, sorts them into map writes and casts, and drops writes
// whose cell lies outside the map.
// ============================================================================
module drc_front #(
    parameter int MAP_SIDE = drc_pkg::MAP_SIDE_DEF
) (
    input  logic              i_in_valid,
    input  drc_pkg::t_drc_in  i_in_data,
    input  logic              i_q_full,
    input  logic              i_clearing,
    output logic              o_in_stall,
    output logic              o_push,
    output drc_pkg::t_drc_op  o_op
);
    localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;

    logic in_map;
    logic take;

    // Hold the input while the queue is full or the map is being cleared
    assign o_in_stall = i_q_full | i_clearing;
    assign take       = i_in_valid & ~o_in_stall;
    assign in_map     = (32'(i_in_data.cell_index) < 32'(MAP_CELLS));

    // Classify the item; a write outside the map is accepted and dropped
    always_comb begin
        o_op.kind      = (i_in_data.mode == drc_pkg::MODE_CAST) ?
                         drc_pkg::K_CAST : drc_pkg::K_WRITE;
        o_op.column    = i_in_data.column;
        o_op.cell_addr = i_in_data.cell_index;
        o_op.wall      = i_in_data.cell_is_wall;
        o_push         = take & ((i_in_data.mode == drc_pkg::MODE_CAST) | in_map);
    end

endmodule

>>> rtl/drc_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_queue
// Short FIFO of classified items between the front and the back.
// ============================================================================
module drc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  drc_pkg::t_drc_op  i_op,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output drc_pkg::t_drc_op  o_op
);
    localparam int D  = drc_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int NW = $clog2(D + 1);

    drc_pkg::t_drc_op r_buf [D];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [NW-1:0]    r_cnt;
    logic [PW-1:0]    n_wptr;
    logic [PW-1:0]    n_rptr;

    assign o_full  = (r_cnt == NW'(D));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_buf[r_rptr];

    // Wrap the pointers at the depth
    always_comb begin
        n_wptr = (r_wptr == PW'(D - 1)) ? '0 : r_wptr + 1'b1;
        n_rptr = (r_rptr == PW'(D - 1)) ? '0 : r_rptr + 1'b1;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_op;
        end
    end

endmodule

>>> rtl/drc_back.sv
`timescale 1ns / 1ps
// ============================================================================
// drc_back
// Executes queued items: map writes, and the ray cast sequence (camera and
// ray, deltas, DDA walk over the map memory, distance, span and texture).
// ============================================================================
module drc_back #(
    parameter int MAP_SIDE   = drc_pkg::MAP_SIDE_DEF,
    parameter int TEX_SIZE   = drc_pkg::TEX_SIZE_DEF,
    parameter int MAX_SCREEN = drc_pkg::MAX_SCREEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drc_pkg::t_drc_cfg  i_cfg,
    input  logic               i_q_empty,
    input  drc_pkg::t_drc_op   i_q_op,
    output logic               o_pop,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output drc_pkg::t_drc_out  o_out_data
);
    localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int CW        = $clog2(MAP_SIDE) + 2;
    localparam int DW        = drc_pkg::DIV_W;
    localparam int SW        = drc_pkg::SCR_W;
    localparam logic [40:0] DELTA_SAT = 41'h100_0000_0000;
    localparam logic [24:0] SAT25     = 25'h1FF_FFFF;
    localparam logic [DW-1:0] ONE_Q30 = DW'(32'h4000_0000);

    // Map memory
    logic           r_map [MAP_DEPTH];
    logic           r_rdata;
    logic           map_we;
    logic [AW-1:0]  map_waddr;
    logic           map_wdata;
    logic [AW-1:0]  rd_addr;

    // Divider port
    logic           div_start;
    logic [DW-1:0]  div_num;
    logic [DW-1:0]  div_den;
    logic           div_done;
    logic [DW-1:0]  div_q;

    // Sequencer registers
    drc_pkg::t_drc_state r_state, n_state;
    drc_pkg::t_drc_state r_ret, n_ret;
    logic [AW-1:0]       r_clr, n_clr;
    logic [10:0]         r_col, n_col;
    logic [SW-1:0]       r_h, n_h;
    logic signed [27:0]  r_cam, n_cam;
    logic signed [31:0]  r_rx, n_rx;
    logic signed [31:0]  r_ry, n_ry;
    logic [40:0]         r_dx, n_dx;
    logic [40:0]         r_dy, n_dy;
    logic [49:0]         r_sdx, n_sdx;
    logic [49:0]         r_sdy, n_sdy;
    logic signed [CW-1:0] r_mx, n_mx;
    logic signed [CW-1:0] r_my, n_my;
    logic                r_side, n_side;
    logic [15:0]         r_dist, n_dist;
    logic [15:0]         r_lh, n_lh;
    logic [21:0]         r_frac, n_frac;
    logic [10:0]         r_tx, n_tx;
    logic [24:0]         r_tstep, n_tstep;
    logic signed [17:0]  r_toff, n_toff;
    drc_pkg::t_drc_out   r_res, n_res;
    drc_pkg::t_drc_out   r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // Datapath terms
    logic [SW-1:0]       w_cl;
    logic [SW-1:0]       h_cl;
    logic signed [43:0]  prod_x;
    logic signed [43:0]  prod_y;
    logic [31:0]         abs_rx;
    logic [31:0]         abs_ry;
    logic [5:0]          pmx;
    logic [5:0]          pmy;
    logic                start_out;
    logic [8:0]          fx;
    logic [8:0]          fy;
    logic [49:0]         side_px;
    logic [49:0]         side_py;
    logic                step_x;
    logic signed [CW-1:0] nmx;
    logic signed [CW-1:0] nmy;
    logic                step_out;
    logic [19:0]         num_base;
    logic signed [19:0]  num_s;
    logic [19:0]         num_abs;
    logic                den_zero;
    logic [37:0]         wall_p;
    logic [21:0]         wall_frac;
    logic [15:0]         lh_v;
    logic [32:0]         tex_p;
    logic [10:0]         tx_raw;
    logic                mirror;
    logic [24:0]         tstep_v;
    logic [11:0]         h2;
    logic [14:0]         lh2;
    logic signed [17:0]  ds_s;
    logic [11:0]         ds_v;
    logic [16:0]         de_u;
    logic [12:0]         de_v;
    logic signed [43:0]  tstart_p;
    logic [24:0]         tstart_v;
    logic [1:0]          face_v;

    drc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Clamp screen sizes to one..MAX_SCREEN
    always_comb begin
        if (i_cfg.screen_width == '0) begin
            w_cl = SW'(1);
        end else if (SW'(i_cfg.screen_width) > SW'(MAX_SCREEN)) begin
            w_cl = SW'(MAX_SCREEN);
        end else begin
            w_cl = SW'(i_cfg.screen_width);
        end
        if (i_cfg.screen_height == '0) begin
            h_cl = SW'(1);
        end else if (SW'(i_cfg.screen_height) > SW'(MAX_SCREEN)) begin
            h_cl = SW'(MAX_SCREEN);
        end else begin
            h_cl = SW'(i_cfg.screen_height);
        end
    end

    // Ray components and start cell
    assign prod_x    = $signed(i_cfg.plane_x) * r_cam;
    assign prod_y    = $signed(i_cfg.plane_y) * r_cam;
    assign abs_rx    = r_rx[31] ? 32'(-r_rx) : 32'(r_rx);
    assign abs_ry    = r_ry[31] ? 32'(-r_ry) : 32'(r_ry);
    assign pmx       = i_cfg.player_x[13:8];
    assign pmy       = i_cfg.player_y[13:8];
    assign start_out = (32'(pmx) >= 32'(MAP_SIDE)) || (32'(pmy) >= 32'(MAP_SIDE));

    // Start side distances
    assign fx      = r_rx[31] ? 9'(i_cfg.player_x[7:0]) : 9'd256 - 9'(i_cfg.player_x[7:0]);
    assign fy      = r_ry[31] ? 9'(i_cfg.player_y[7:0]) : 9'd256 - 9'(i_cfg.player_y[7:0]);
    assign side_px = 50'(fx) * 50'(r_dx);
    assign side_py = 50'(fy) * 50'(r_dy);

    // DDA step: pick the nearer border and move one cell
    assign step_x   = (r_sdx < r_sdy);
    assign nmx      = step_x ? r_mx + (r_rx[31] ? {CW{1'b1}} : CW'(1)) : r_mx;
    assign nmy      = step_x ? r_my : r_my + (r_ry[31] ? {CW{1'b1}} : CW'(1));
    assign step_out = nmx[CW-1] || nmy[CW-1] ||
                      ($unsigned(nmx) >= CW'(MAP_SIDE)) ||
                      ($unsigned(nmy) >= CW'(MAP_SIDE));
    assign rd_addr  = AW'(32'(nmx[CW-2:0]) * 32'(MAP_SIDE) + 32'(nmy[CW-2:0]));

    // Distance numerator and divisor of the hit side
    always_comb begin
        if (!r_side) begin
            num_base = (20'(r_mx[CW-2:0]) << 8) + (r_rx[31] ? 20'd256 : 20'd0);
            num_s    = $signed(num_base) - $signed(20'(i_cfg.player_x));
            den_zero = (r_rx == '0);
        end else begin
            num_base = (20'(r_my[CW-2:0]) << 8) + (r_ry[31] ? 20'd256 : 20'd0);
            num_s    = $signed(num_base) - $signed(20'(i_cfg.player_y));
            den_zero = (r_ry == '0);
        end
        num_abs = num_s[19] ? 20'(-num_s) : 20'(num_s);
    end

    // Wall hit point, low 22 bits of the Q.22 coordinate
    always_comb begin
        if (!r_side) begin
            wall_p    = 38'(r_dist) * 38'(r_ry[21:0]);
            wall_frac = wall_p[21:0] + {i_cfg.player_y[7:0], 14'd0};
        end else begin
            wall_p    = 38'(r_dist) * 38'(r_rx[21:0]);
            wall_frac = wall_p[21:0] + {i_cfg.player_x[7:0], 14'd0};
        end
    end

    // Line height and texture column
    assign lh_v   = (r_dist == '0) ? 16'hFFFF :
                    ((div_q > DW'(16'hFFFF)) ? 16'hFFFF : div_q[15:0]);
    assign tex_p  = 33'(r_frac) * 33'(TEX_SIZE);
    assign tx_raw = tex_p[32:22];
    assign mirror = (!r_side && !r_rx[31] && (r_rx != '0)) || (r_side && r_ry[31]);

    // Texture step, draw span and texture offset
    always_comb begin
        if (r_lh == '0) begin
            tstep_v = SAT25;
        end else if (div_q > DW'(SAT25)) begin
            tstep_v = SAT25;
        end else begin
            tstep_v = div_q[24:0];
        end
        h2   = r_h[SW-1:1];
        lh2  = r_lh[15:1];
        ds_s = $signed(18'(h2)) - $signed(18'(lh2));
        ds_v = ds_s[17] ? 12'd0 : ds_s[11:0];
        de_u = 17'(lh2) + 17'(h2);
        de_v = (de_u >= 17'(r_h)) ? 13'(r_h - 1'b1) : de_u[12:0];
        if (!r_side) begin
            face_v = r_rx[31] ? drc_pkg::FACE_S : drc_pkg::FACE_N;
        end else begin
            face_v = r_ry[31] ? drc_pkg::FACE_E : drc_pkg::FACE_W;
        end
    end

    // Texture start row, clamped to the Q9.16 range
    assign tstart_p = r_toff * $signed({1'b0, r_tstep});
    assign tstart_v = tstart_p[43] ? 25'd0 :
                      ((tstart_p > 44'(SAT25)) ? SAT25 : tstart_p[24:0]);

    // Sequencer: next state and datapath loads
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_clr       = r_clr;
        n_col       = r_col;
        n_h         = r_h;
        n_cam       = r_cam;
        n_rx        = r_rx;
        n_ry        = r_ry;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_sdx       = r_sdx;
        n_sdy       = r_sdy;
        n_mx        = r_mx;
        n_my        = r_my;
        n_side      = r_side;
        n_dist      = r_dist;
        n_lh        = r_lh;
        n_frac      = r_frac;
        n_tx        = r_tx;
        n_tstep     = r_tstep;
        n_toff      = r_toff;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        map_we      = 1'b0;
        map_waddr   = r_clr;
        map_wdata   = 1'b0;
        o_pop       = 1'b0;

        case (r_state)
            // Sweep the map to empty after reset
            drc_pkg::S_CLEAR: begin
                map_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (r_clr == AW'(MAP_DEPTH - 1)) begin
                    n_state = drc_pkg::S_IDLE;
                end
            end
            // Take the next item: write a cell, or start a cast with the camera x
            drc_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_q_op.kind == drc_pkg::K_WRITE) begin
                        map_we    = 1'b1;
                        map_waddr = AW'(i_q_op.cell_addr);
                        map_wdata = i_q_op.wall;
                    end else begin
                        n_col     = i_q_op.column;
                        n_h       = h_cl;
                        div_start = 1'b1;
                        div_num   = DW'(i_q_op.column) << 15;
                        div_den   = DW'(w_cl);
                        n_ret     = drc_pkg::S_CAM;
                        n_state   = drc_pkg::S_DIV;
                    end
                end
            end
            // Wait for the divider
            drc_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = r_ret;
                end
            end
            drc_pkg::S_CAM: begin
                n_cam   = $signed({1'b0, div_q[26:0]}) - 28'sd16384;
                n_state = drc_pkg::S_RAY;
            end
            // Ray direction and start cell
            drc_pkg::S_RAY: begin
                n_rx = $signed({{16{i_cfg.dir_x[15]}}, i_cfg.dir_x}) +
                       $signed({{2{prod_x[43]}}, prod_x[43:14]});
                n_ry = $signed({{16{i_cfg.dir_y[15]}}, i_cfg.dir_y}) +
                       $signed({{2{prod_y[43]}}, prod_y[43:14]});
                n_mx = CW'(pmx);
                n_my = CW'(pmy);
                if (start_out) begin
                    n_res            = '0;
                    n_res.column_out = r_col;
                    n_res.status     = drc_pkg::ST_LEFT;
                    n_state          = drc_pkg::S_ST;
                    n_ret            = drc_pkg::S_IDLE;
                end else begin
                    n_state = drc_pkg::S_DXI;
                end
            end
            drc_pkg::S_DXI: begin
                div_start = 1'b1;
                div_num   = ONE_Q30;
                div_den   = abs_rx;
                n_ret     = drc_pkg::S_DX;
                n_state   = drc_pkg::S_DIV;
            end
            drc_pkg::S_DX: begin
                n_dx      = (r_rx == '0) ? DELTA_SAT : 41'(div_q);
                div_start = 1'b1;
                div_num   = ONE_Q30;
                div_den   = abs_ry;
                n_ret     = drc_pkg::S_DY;
                n_state   = drc_pkg::S_DIV;
            end
            drc_pkg::S_DY: begin
                n_dy    = (r_ry == '0) ? DELTA_SAT : 41'(div_q);
                n_state = drc_pkg::S_SIDE;
            end
            drc_pkg::S_SIDE: begin
                n_sdx   = side_px >> 8;
                n_sdy   = side_py >> 8;
                n_state = drc_pkg::S_STEP;
            end
            // Advance one cell and read it, or stop at the map edge
            drc_pkg::S_STEP: begin
                n_mx = nmx;
                n_my = nmy;
                if (step_x) begin
                    n_sdx  = r_sdx + 50'(r_dx);
                    n_side = 1'b0;
                end else begin
                    n_sdy  = r_sdy + 50'(r_dy);
                    n_side = 1'b1;
                end
                if (step_out) begin
                    n_res            = '0;
                    n_res.column_out = r_col;
                    n_res.status     = drc_pkg::ST_LEFT;
                    n_state          = drc_pkg::S_ST;
                    n_ret            = drc_pkg::S_IDLE;
                end else begin
                    n_state = drc_pkg::S_CHECK;
                end
            end
            // On a wall, divide for the perpendicular distance
            drc_pkg::S_CHECK: begin
                if (r_rdata) begin
                    div_start = 1'b1;
                    div_num   = DW'(num_abs) << 14;
                    div_den   = r_side ? abs_ry : abs_rx;
                    n_ret     = drc_pkg::S_DIST;
                    n_state   = drc_pkg::S_DIV;
                end else begin
                    n_state = drc_pkg::S_STEP;
                end
            end
            drc_pkg::S_DIST: begin
                if (den_zero || (div_q > DW'(16'hFFFF))) begin
                    n_dist = 16'hFFFF;
                end else begin
                    n_dist = div_q[15:0];
                end
                n_state = drc_pkg::S_LHI;
            end
            drc_pkg::S_LHI: begin
                n_frac    = wall_frac;
                div_start = 1'b1;
                div_num   = DW'(r_h) << 8;
                div_den   = DW'(r_dist);
                n_ret     = drc_pkg::S_LH;
                n_state   = drc_pkg::S_DIV;
            end
            drc_pkg::S_LH: begin
                n_lh      = lh_v;
                n_tx      = mirror ? 11'(TEX_SIZE) - tx_raw - 11'd1 : tx_raw;
                div_start = 1'b1;
                div_num   = DW'(TEX_SIZE) << 16;
                div_den   = DW'(lh_v);
                n_ret     = drc_pkg::S_TS;
                n_state   = drc_pkg::S_DIV;
            end
            drc_pkg::S_TS: begin
                n_tstep             = tstep_v;
                n_toff              = $signed(18'(ds_v)) - $signed(18'(h2)) +
                                      $signed(18'(lh2));
                n_res.column_out    = r_col;
                n_res.status        = drc_pkg::ST_HIT;
                n_res.wall_face     = face_v;
                n_res.wall_distance = r_dist;
                n_res.line_height   = r_lh;
                n_res.draw_start    = ds_v[10:0];
                n_res.draw_end      = de_v[10:0];
                n_res.tex_x         = r_tx[8:0];
                n_res.tex_step      = tstep_v;
                n_ret               = drc_pkg::S_ST;
                n_state             = drc_pkg::S_ST;
            end
            // Finish the texture start, then hand the item to the output register
            drc_pkg::S_ST: begin
                if (r_ret == drc_pkg::S_ST) begin
                    n_res.tex_start = tstart_v;
                    n_ret           = drc_pkg::S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = drc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = drc_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= drc_pkg::S_CLEAR;
            r_ret       <= drc_pkg::S_IDLE;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_col   <= n_col;
        r_h     <= n_h;
        r_cam   <= n_cam;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_sdx   <= n_sdx;
        r_sdy   <= n_sdy;
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_side  <= n_side;
        r_dist  <= n_dist;
        r_lh    <= n_lh;
        r_frac  <= n_frac;
        r_tx    <= n_tx;
        r_tstep <= n_tstep;
        r_toff  <= n_toff;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Map memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_map[rd_addr];
    end

    assign o_clearing  = (r_state == drc_pkg::S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
